// ===== sv/jsof_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsof_pkg
// Shared types, marker codes and helpers for the JPEG frame-size parser.
// ----------------------------------------------------------------------------
package jsof_pkg;

  localparam logic [7:0] MARKER_PREFIX = 8'hFF;
  localparam logic [7:0] MARKER_SOI    = 8'hD8;
  localparam logic [7:0] MARKER_EOI    = 8'hD9;
  localparam logic [7:0] MARKER_SOS    = 8'hDA;
  localparam logic [7:0] MARKER_TEM    = 8'h01;

  // payload bytes counted up to this value, then held
  localparam logic [2:0] PREFIX_FULL   = 3'd4;
  // sof body offset counted up to this value, then held
  localparam logic [2:0] OFFSET_FULL   = 3'd5;

  typedef enum logic [7:0] {
    PH_SOI0  = 8'b0000_0001,
    PH_SOI1  = 8'b0000_0010,
    PH_MARK  = 8'b0000_0100,
    PH_FILL  = 8'b0000_1000,
    PH_LENHI = 8'b0001_0000,
    PH_LENLO = 8'b0010_0000,
    PH_BODY  = 8'b0100_0000,
    PH_DONE  = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_SOF   = 2'd1,
    CLS_SOS   = 2'd2
  } marker_class_t;

  typedef enum logic [2:0] {
    ST_FOUND       = 3'd0,
    ST_NO_SOI      = 3'd1,
    ST_BAD_MARKER  = 3'd2,
    ST_TRUNC_LEN   = 3'd3,
    ST_BAD_SEG_LEN = 3'd4,
    ST_SHORT_SOF   = 3'd5,
    ST_ZERO_SIZE   = 3'd6,
    ST_NOT_FOUND   = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } result_t;

  function automatic logic is_frame_marker(input logic [7:0] m);
    return (m >= 8'hC0 && m <= 8'hC3) || (m >= 8'hC5 && m <= 8'hC7) ||
           (m >= 8'hC9 && m <= 8'hCB) || (m >= 8'hCD && m <= 8'hCF);
  endfunction

  function automatic logic is_lone_marker(input logic [7:0] m);
    return (m == MARKER_TEM) || (m >= 8'hD0 && m <= 8'hD9);
  endfunction

endpackage

// ===== sv/jsof_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsof_byte_if
// Valid/ready channel carrying one payload byte with first/last marks.
// ----------------------------------------------------------------------------
interface jsof_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte,
                  output last_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte,
                  input last_byte, output ready);
endinterface

// ===== sv/jsof_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsof_result_if
// Valid/ready channel carrying one parse result: status and frame size.
// ----------------------------------------------------------------------------
interface jsof_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] image_width;
  logic [15:0] image_height;

  modport source (output valid, output status, output image_width,
                  output image_height, input ready);
  modport sink   (input valid, input status, input image_width,
                  input image_height, output ready);
endinterface

// ===== sv/jsof_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsof_step
// Parser state registers and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module jsof_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  jsof_pkg::item_t item,
  output logic            hit,
  output jsof_pkg::result_t result
);
  import jsof_pkg::*;

  phase_t        phase;
  logic [2:0]    prefix_count;
  logic [7:0]    length_high;
  logic [15:0]   segment_remaining;
  logic [2:0]    segment_offset;
  marker_class_t marker_class;
  logic [15:0]   frame_height;
  logic [15:0]   frame_width;

  phase_t        cur_phase;
  logic [2:0]    cur_prefix;
  logic [7:0]    cur_length_high;
  logic [15:0]   cur_remaining;
  logic [2:0]    cur_offset;
  marker_class_t cur_class;
  logic [15:0]   cur_height;
  logic [15:0]   cur_width;

  phase_t        phase_next;
  logic [2:0]    prefix_count_next;
  logic [7:0]    length_high_next;
  logic [15:0]   segment_remaining_next;
  logic [2:0]    segment_offset_next;
  marker_class_t marker_class_next;
  logic [15:0]   frame_height_next;
  logic [15:0]   frame_width_next;

  logic [15:0]   seg_len;
  logic          seg_end;
  logic          have_status;
  status_t       status;

  // a first byte restarts from the reset state
  always_comb begin
    if (item.first_byte) begin
      cur_phase       = PH_SOI0;
      cur_prefix      = '0;
      cur_length_high = '0;
      cur_remaining   = '0;
      cur_offset      = '0;
      cur_class       = CLS_OTHER;
      cur_height      = '0;
      cur_width       = '0;
    end else begin
      cur_phase       = phase;
      cur_prefix      = prefix_count;
      cur_length_high = length_high;
      cur_remaining   = segment_remaining;
      cur_offset      = segment_offset;
      cur_class       = marker_class;
      cur_height      = frame_height;
      cur_width       = frame_width;
    end
  end

  always_comb begin
    phase_next             = cur_phase;
    prefix_count_next      = cur_prefix;
    length_high_next       = cur_length_high;
    segment_remaining_next = cur_remaining;
    segment_offset_next    = cur_offset;
    marker_class_next      = cur_class;
    frame_height_next      = cur_height;
    frame_width_next       = cur_width;
    seg_len                = {cur_length_high, item.data_byte};
    seg_end                = 1'b0;
    have_status            = 1'b0;
    status                 = ST_FOUND;

    if (cur_phase != PH_DONE) begin
      if (cur_prefix < PREFIX_FULL) begin
        prefix_count_next = cur_prefix + 3'd1;
      end

      if (item.last_byte && prefix_count_next < PREFIX_FULL) begin
        have_status = 1'b1;
        status      = ST_NO_SOI;
      end else begin
        unique case (cur_phase)
          PH_SOI0: begin
            if (item.data_byte != MARKER_PREFIX) begin
              have_status = 1'b1;
              status      = ST_NO_SOI;
            end else begin
              phase_next = PH_SOI1;
            end
          end
          PH_SOI1: begin
            if (item.data_byte != MARKER_SOI) begin
              have_status = 1'b1;
              status      = ST_NO_SOI;
            end else begin
              phase_next = PH_MARK;
            end
          end
          PH_MARK: begin
            if (item.data_byte != MARKER_PREFIX) begin
              have_status = 1'b1;
              status      = ST_BAD_MARKER;
            end else begin
              phase_next = PH_FILL;
            end
          end
          PH_FILL: begin
            if (item.data_byte == MARKER_PREFIX) begin
              phase_next = PH_FILL;
            end else if (is_lone_marker(item.data_byte)) begin
              if (item.data_byte == MARKER_EOI) begin
                have_status = 1'b1;
                status      = ST_NOT_FOUND;
              end else begin
                phase_next = PH_MARK;
              end
            end else begin
              if (item.data_byte == MARKER_SOS) begin
                marker_class_next = CLS_SOS;
              end else if (is_frame_marker(item.data_byte)) begin
                marker_class_next = CLS_SOF;
              end else begin
                marker_class_next = CLS_OTHER;
              end
              phase_next = PH_LENHI;
            end
          end
          PH_LENHI: begin
            length_high_next = item.data_byte;
            phase_next       = PH_LENLO;
          end
          PH_LENLO: begin
            if (seg_len < 16'd2) begin
              have_status = 1'b1;
              status      = ST_BAD_SEG_LEN;
            end else begin
              segment_remaining_next = seg_len - 16'd2;
              segment_offset_next    = '0;
              phase_next             = PH_BODY;
              seg_end                = (seg_len == 16'd2);
            end
          end
          PH_BODY: begin
            if (cur_class == CLS_SOF) begin
              if (cur_offset == 3'd1 || cur_offset == 3'd2) begin
                frame_height_next = {cur_height[7:0], item.data_byte};
              end else if (cur_offset == 3'd3 || cur_offset == 3'd4) begin
                frame_width_next = {cur_width[7:0], item.data_byte};
              end
            end
            if (cur_offset < OFFSET_FULL) begin
              segment_offset_next = cur_offset + 3'd1;
            end
            segment_remaining_next = cur_remaining - 16'd1;
            seg_end                = (segment_remaining_next == 16'd0);
          end
          default: begin
            phase_next = PH_DONE;
          end
        endcase

        // all bytes of a segment are in
        if (seg_end) begin
          if (marker_class_next == CLS_SOS) begin
            have_status = 1'b1;
            status      = ST_NOT_FOUND;
          end else if (marker_class_next == CLS_SOF) begin
            have_status = 1'b1;
            if (segment_offset_next < OFFSET_FULL) begin
              status = ST_SHORT_SOF;
            end else if (frame_height_next == 16'd0 || frame_width_next == 16'd0) begin
              status = ST_ZERO_SIZE;
            end else begin
              status = ST_FOUND;
            end
          end else begin
            phase_next = PH_MARK;
          end
        end
      end

      // payload ended with no verdict yet
      if (!have_status && item.last_byte) begin
        have_status = 1'b1;
        if (phase_next == PH_LENHI || phase_next == PH_LENLO) begin
          status = ST_TRUNC_LEN;
        end else if (phase_next == PH_BODY) begin
          status = ST_BAD_SEG_LEN;
        end else begin
          status = ST_NOT_FOUND;
        end
      end

      if (have_status) begin
        phase_next = PH_DONE;
      end
    end
  end

  always_comb begin
    hit           = have_status;
    result.status = status;
    if (status == ST_FOUND) begin
      result.image_width  = frame_width_next;
      result.image_height = frame_height_next;
    end else begin
      result.image_width  = '0;
      result.image_height = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_SOI0;
      prefix_count      <= '0;
      length_high       <= '0;
      segment_remaining <= '0;
      segment_offset    <= '0;
      marker_class      <= CLS_OTHER;
      frame_height      <= '0;
      frame_width       <= '0;
    end else if (take) begin
      phase             <= phase_next;
      prefix_count      <= prefix_count_next;
      length_high       <= length_high_next;
      segment_remaining <= segment_remaining_next;
      segment_offset    <= segment_offset_next;
      marker_class      <= marker_class_next;
      frame_height      <= frame_height_next;
      frame_width       <= frame_width_next;
    end
  end

endmodule

// ===== sv/jpeg_sof_dimension_parser.sv =====
`timescale 1ns / 1ps
// a byte is held in the input register, and its result in the output register
// throughput: one byte per cycle while results are taken; the input register
//   holds one byte while a finished result waits on the output register
// one result per payload; bytes after it are dropped until the next first byte
// reset (rst, synchronous) empties both registers and waits for a first SOI byte
// ----------------------------------------------------------------------------
// jpeg_sof_dimension_parser
// Walks JPEG marker segments byte by byte and reports the first SOF frame size.
// ----------------------------------------------------------------------------
module jpeg_sof_dimension_parser (
  input  logic         clk,
  input  logic         rst,
  jsof_byte_if.sink    payload_bytes,
  jsof_result_if.source frame_result
);
  import jsof_pkg::*;

  logic    hold_valid;
  item_t   hold_item;
  logic    take;
  logic    hit;
  result_t step_result;
  logic    out_valid;
  result_t out_result;

  // byte leaves the input register only when the result slot can take it
  assign take                = hold_valid && (!out_valid || frame_result.ready);
  assign payload_bytes.ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (payload_bytes.valid && payload_bytes.ready) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (payload_bytes.valid && payload_bytes.ready) begin
      hold_item.data_byte  <= payload_bytes.data_byte;
      hold_item.first_byte <= payload_bytes.first_byte;
      hold_item.last_byte  <= payload_bytes.last_byte;
    end
  end

  jsof_step u_step (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .item   (hold_item),
    .hit    (hit),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && hit) begin
      out_valid <= 1'b1;
    end else if (frame_result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && hit) begin
      out_result <= step_result;
    end
  end

  assign frame_result.valid        = out_valid;
  assign frame_result.status       = out_result.status;
  assign frame_result.image_width  = out_result.image_width;
  assign frame_result.image_height = out_result.image_height;

endmodule

// ===== sim/jpeg_sof_dimension_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_sof_dimension_parser_tb
// Feeds JPEG payloads byte by byte into the frame-size parser. The payloads
// are a few hand-built ones followed by random ones, mostly well formed with
// random segments, cuts and corrupted bytes. A byte-level tracker of the
// marker walk predicts each result, and every result is checked field by field
// in order. Sender idling and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module jpeg_sof_dimension_parser_tb;
  import jsof_pkg::*;

  logic clk;
  logic rst;

  jsof_byte_if   bytes_if();
  jsof_result_if result_if();

  jpeg_sof_dimension_parser uut (
    .clk          (clk),
    .rst          (rst),
    .payload_bytes(bytes_if),
    .frame_result (result_if)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // idling per phase, in percent of cycles
  int send_idle_plan [4] = '{0, 71, 0, 24};
  int stall_plan     [4] = '{0, 0, 71, 24};
  int send_idle_pct;
  int stall_pct;

  item_t       pending_bytes[$];
  item_t       on_wire;
  result_t     expected_sizes[$];
  result_t     want;
  logic [7:0]  payload_buf[$];
  int          queued_total;
  int          accepted_count;
  int          error_count;

  // tracker of the marker walk
  phase_t        trk_phase;
  logic [2:0]    trk_count;
  logic [7:0]    trk_len_hi;
  logic [15:0]   trk_left;
  logic [2:0]    trk_offset;
  marker_class_t trk_class;
  logic [15:0]   trk_height;
  logic [15:0]   trk_width;
  logic          trk_reported;

  function automatic logic sof_code(input logic [7:0] b);
    return (b >= 8'hC0 && b <= 8'hCF) && !(b inside {8'hC4, 8'hC8, 8'hCC});
  endfunction

  function automatic logic standalone_code(input logic [7:0] b);
    return b == MARKER_TEM || (b >= 8'hD0 && b <= 8'hD9);
  endfunction

  task automatic restart_tracker();
    trk_phase    = PH_SOI0;
    trk_count    = '0;
    trk_len_hi   = '0;
    trk_left     = '0;
    trk_offset   = '0;
    trk_class    = CLS_OTHER;
    trk_height   = '0;
    trk_width    = '0;
    trk_reported = 1'b0;
  endtask

  // sof and sos segments are judged once their last byte is in
  task automatic close_segment(output int st);
    st = -1;
    if (trk_class == CLS_SOS) begin
      st = ST_NOT_FOUND;
    end else if (trk_class == CLS_SOF) begin
      if (trk_offset < OFFSET_FULL) st = ST_SHORT_SOF;
      else if (trk_height == 16'd0 || trk_width == 16'd0) st = ST_ZERO_SIZE;
      else st = ST_FOUND;
    end else begin
      trk_phase = PH_MARK;
    end
  endtask

  task automatic track_frame_size(input item_t it);
    int         st;
    int         seg_len;
    logic [7:0] b;
    result_t    r;
    st = -1;
    b  = it.data_byte;
    if (it.first_byte) restart_tracker();
    if (trk_phase == PH_DONE || trk_reported) return;
    if (trk_count < PREFIX_FULL) trk_count++;
    if (it.last_byte && trk_count < PREFIX_FULL) begin
      st = ST_NO_SOI;
    end else begin
      case (trk_phase)
        PH_SOI0: begin
          if (b != MARKER_PREFIX) st = ST_NO_SOI;
          else trk_phase = PH_SOI1;
        end
        PH_SOI1: begin
          if (b != MARKER_SOI) st = ST_NO_SOI;
          else trk_phase = PH_MARK;
        end
        PH_MARK: begin
          if (b != MARKER_PREFIX) st = ST_BAD_MARKER;
          else trk_phase = PH_FILL;
        end
        PH_FILL: begin
          // extra 0xff bytes are fill
          if (b != MARKER_PREFIX) begin
            if (standalone_code(b)) begin
              if (b == MARKER_EOI) st = ST_NOT_FOUND;
              else trk_phase = PH_MARK;
            end else begin
              if (b == MARKER_SOS) trk_class = CLS_SOS;
              else if (sof_code(b)) trk_class = CLS_SOF;
              else trk_class = CLS_OTHER;
              trk_phase = PH_LENHI;
            end
          end
        end
        PH_LENHI: begin
          trk_len_hi = b;
          trk_phase  = PH_LENLO;
        end
        PH_LENLO: begin
          seg_len = {trk_len_hi, b};
          if (seg_len < 2) begin
            st = ST_BAD_SEG_LEN;
          end else begin
            trk_left   = 16'(seg_len - 2);
            trk_offset = '0;
            trk_phase  = PH_BODY;
            if (trk_left == 16'd0) close_segment(st);
          end
        end
        PH_BODY: begin
          if (trk_class == CLS_SOF) begin
            if (trk_offset == 3'd1 || trk_offset == 3'd2)
              trk_height = {trk_height[7:0], b};
            else if (trk_offset == 3'd3 || trk_offset == 3'd4)
              trk_width = {trk_width[7:0], b};
          end
          if (trk_offset < OFFSET_FULL) trk_offset++;
          trk_left = trk_left - 16'd1;
          if (trk_left == 16'd0) close_segment(st);
        end
        default: ;
      endcase
    end
    if (st < 0 && it.last_byte) begin
      if (trk_phase == PH_LENHI || trk_phase == PH_LENLO) st = ST_TRUNC_LEN;
      else if (trk_phase == PH_BODY) st = ST_BAD_SEG_LEN;
      else st = ST_NOT_FOUND;
    end
    if (st >= 0) begin
      r.status       = status_t'(st[2:0]);
      r.image_width  = (st == ST_FOUND) ? trk_width : 16'd0;
      r.image_height = (st == ST_FOUND) ? trk_height : 16'd0;
      expected_sizes.insert(expected_sizes.size(), r);
      trk_phase    = PH_DONE;
      trk_reported = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    error_count++;
  endtask

  task automatic push_byte(input logic [7:0] data, input logic first, input logic last);
    item_t it;
    it.data_byte  = data;
    it.first_byte = first;
    it.last_byte  = last;
    pending_bytes.insert(pending_bytes.size(), it);
    queued_total++;
  endtask

  // appends one byte to the payload being built
  task automatic buf_add(input logic [7:0] v);
    payload_buf.insert(payload_buf.size(), v);
  endtask

  task automatic put_marker(input logic [7:0] code);
    buf_add(MARKER_PREFIX);
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 2)) buf_add(MARKER_PREFIX);
    buf_add(code);
  endtask

  task automatic put_segment(input logic [7:0] code, input int seg_len, input int body_n);
    logic [15:0] len_field;
    len_field = 16'(seg_len);
    put_marker(code);
    buf_add(len_field[15:8]);
    buf_add(len_field[7:0]);
    repeat (body_n) buf_add(8'($urandom_range(255)));
  endtask

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd1;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // mostly a well-formed stream up to the first sof, then cuts and corruption
  task automatic queue_payload();
    int          i;
    int          seg_len;
    int          stop_at;
    logic        keep_last;
    logic [7:0]  code;
    logic [15:0] h;
    logic [15:0] w;
    payload_buf.delete();
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(1, 8)) buf_add(8'($urandom_range(255)));
    end else begin
      buf_add(MARKER_PREFIX);
      buf_add(MARKER_SOI);
      repeat ($urandom_range(3)) begin
        case ($urandom_range(9))
          0, 1, 2: begin
            code = ($urandom_range(9) == 9) ? MARKER_TEM : 8'(8'hD0 + $urandom_range(8));
            put_marker(code);
          end
          3: put_marker(MARKER_EOI);
          4: begin
            seg_len = $urandom_range(2, 5);
            put_segment(MARKER_SOS, seg_len, seg_len - 2);
          end
          default: begin
            do code = 8'($urandom_range(255));
            while (sof_code(code) || standalone_code(code) ||
                   code == MARKER_SOS || code == MARKER_PREFIX);
            if ($urandom_range(7) == 0) begin
              put_segment(code, $urandom_range(65535), $urandom_range(6));
            end else begin
              seg_len = $urandom_range(2, 6);
              put_segment(code, seg_len, seg_len - 2);
            end
          end
        endcase
      end
      h = pick_dim();
      w = pick_dim();
      seg_len = ($urandom_range(5) == 0) ? $urandom_range(7) : 8 + $urandom_range(3);
      do code = 8'($urandom_range(8'hC0, 8'hCF));
      while (!sof_code(code));
      put_segment(code, seg_len, 0);
      for (i = 0; i < seg_len - 2; i++) begin
        case (i)
          0:       buf_add(8'd8);
          1:       buf_add(h[15:8]);
          2:       buf_add(h[7:0]);
          3:       buf_add(w[15:8]);
          4:       buf_add(w[7:0]);
          default: buf_add(8'($urandom_range(255)));
        endcase
      end
      if ($urandom_range(2) == 0) begin
        put_segment(MARKER_SOS, 2, 0);
        put_marker(MARKER_EOI);
      end
    end
    stop_at = payload_buf.size() - 1;
    if ($urandom_range(3) == 0) stop_at = $urandom_range(payload_buf.size() - 1);
    if ($urandom_range(5) == 0)
      payload_buf[$urandom_range(payload_buf.size() - 1)] = 8'($urandom_range(255));
    keep_last = ($urandom_range(11) != 0);
    for (i = 0; i <= stop_at; i++)
      push_byte(payload_buf[i], i == 0, keep_last && i == stop_at);
    // trailing bytes with no first mark
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3))
        push_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      bytes_if.valid <= 1'b0;
    end else begin
      if (bytes_if.valid && bytes_if.ready) begin
        track_frame_size(on_wire);
        accepted_count++;
      end
      if (!bytes_if.valid || bytes_if.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = pending_bytes.pop_front();
          bytes_if.valid      <= 1'b1;
          bytes_if.data_byte  <= on_wire.data_byte;
          bytes_if.first_byte <= on_wire.first_byte;
          bytes_if.last_byte  <= on_wire.last_byte;
        end else begin
          bytes_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= stall_pct);
      if (result_if.valid && result_if.ready) begin
        if (expected_sizes.size() == 0) begin
          report_mismatch($sformatf("unexpected result, status %0d", result_if.status));
        end else begin
          want = expected_sizes.pop_front();
          if (result_if.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      result_if.status, want.status));
          if (result_if.image_width !== want.image_width)
            report_mismatch($sformatf("width %0d, want %0d",
                                      result_if.image_width, want.image_width));
          if (result_if.image_height !== want.image_height)
            report_mismatch($sformatf("height %0d, want %0d",
                                      result_if.image_height, want.image_height));
        end
      end
    end
  end

  initial begin
    int target;
    rst                 = 1'b1;
    bytes_if.valid      = 1'b0;
    bytes_if.data_byte  = 8'd0;
    bytes_if.first_byte = 1'b0;
    bytes_if.last_byte  = 1'b0;
    result_if.ready     = 1'b0;
    send_idle_pct       = 0;
    stall_pct           = 0;
    queued_total        = 0;
    accepted_count      = 0;
    error_count         = 0;
    restart_tracker();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_idle_plan[p];
      stall_pct     = stall_plan[p];
      if (p == 0) begin
        // no first mark right after reset, ends on eoi, then a dropped byte
        push_byte(MARKER_PREFIX, 1'b0, 1'b0);
        push_byte(MARKER_SOI, 1'b0, 1'b0);
        push_byte(MARKER_PREFIX, 1'b0, 1'b0);
        push_byte(MARKER_EOI, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        // largest frame size
        push_byte(MARKER_PREFIX, 1'b1, 1'b0);
        push_byte(MARKER_SOI, 1'b0, 1'b0);
        push_byte(MARKER_PREFIX, 1'b0, 1'b0);
        push_byte(8'hC0, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h07, 1'b0, 1'b0);
        push_byte(8'h08, 1'b0, 1'b0);
        repeat (3) push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b1);
        // one-byte payload
        push_byte(8'h00, 1'b1, 1'b1);
        // restart mid-payload, then a length field below two
        push_byte(MARKER_PREFIX, 1'b1, 1'b0);
        push_byte(MARKER_SOI, 1'b0, 1'b0);
        push_byte(MARKER_PREFIX, 1'b0, 1'b0);
        push_byte(MARKER_PREFIX, 1'b1, 1'b0);
        push_byte(MARKER_SOI, 1'b0, 1'b0);
        push_byte(MARKER_PREFIX, 1'b0, 1'b0);
        push_byte(8'hC1, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b1);
      end
      target = queued_total + 375;
      while (queued_total < target) queue_payload();
      while (accepted_count != queued_total || expected_sizes.size() != 0)
        @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== jpeg_sof_dimension_parser.f =====
sv/jsof_pkg.sv
sv/jsof_byte_if.sv
sv/jsof_result_if.sv
sv/jsof_step.sv
sv/jpeg_sof_dimension_parser.sv
sim/jpeg_sof_dimension_parser_tb.sv
